// File: src/gdil_pkg.sv
// Shared types, constants and codes of the glyph outline dilation unit.
package gdil_pkg;

    // default sizing, handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_THICK  = 4;

    // job field widths, sized for the largest legal parameters
    localparam int JOB_X_W    = 9;
    localparam int JOB_RING_W = 6;
    localparam int JOB_CNT_W  = 6;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THICK  = 2'd2;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] coverage;
        logic       last;
    } t_out_word;

    // one back-end job: optional store write, then a column max over cnt rows
    typedef struct packed {
        logic                  wr;
        logic [7:0]            value;
        logic [JOB_X_W-1:0]    x;
        logic [JOB_RING_W-1:0] ring;
        logic [JOB_CNT_W-1:0]  cnt;
        logic                  last;
    } t_job;

endpackage

// File: src/gdil_queue.sv
// Short job queue between the front and the back part.
module gdil_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gdil_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output gdil_pkg::t_job o_job,
    output logic          o_empty
);
    localparam int PW = $clog2(gdil_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(gdil_pkg::QUEUE_DEPTH + 1);

    gdil_pkg::t_job    r_mem [gdil_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CW'(gdil_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(gdil_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(gdil_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: src/gdil_front.sv
// Front part: configuration, raster counters, running row max and job issue.
module gdil_front #(
    parameter int MAX_WIDTH  = gdil_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gdil_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_THICK  = gdil_pkg::DEF_MAX_THICK
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [6:0]        i_cfg_data,
    input  logic              push,
    output logic              full,
    input  gdil_pkg::t_in_word i_in,
    output logic              o_job_push,
    output gdil_pkg::t_job    o_job,
    input  logic              i_job_full
);
    localparam int R      = 2 * MAX_THICK + 1;
    localparam int STRIDE = MAX_WIDTH + 2 * MAX_THICK;
    localparam int WIN    = 2 * MAX_THICK;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int TW     = $clog2(MAX_THICK + 1);
    localparam int T2W    = $clog2(2 * MAX_THICK + 1);
    localparam int XW     = $clog2(STRIDE);
    localparam int OWW    = $clog2(STRIDE + 1);
    localparam int RW     = $clog2(R);
    localparam int CW     = $clog2(2 * MAX_THICK + 2);

    logic [6:0]     r_cfg_w, r_cfg_h, n_cfg_w, n_cfg_h;
    logic [2:0]     r_cfg_t, n_cfg_t;
    logic [XW-1:0]  r_col, n_col, r_dx, n_dx;
    logic [HW-1:0]  r_row, n_row;
    logic [RW-1:0]  r_ring, n_ring, ring_prev;
    logic [T2W-1:0] r_dy, n_dy, r_e, n_e;
    logic           r_ext, n_ext;
    logic [7:0]     r_win [WIN];
    logic [7:0]     n_win [WIN];

    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic [TW-1:0]  t;
    logic [T2W-1:0] t2, d_rows;
    logic [OWW-1:0] ow;
    logic [7:0]     v_in, row_max;
    logic           acc, col_last, drain_last, restart;
    logic [CW-1:0]  cnt_base, cnt_drain;

    // saturated register values
    assign w = WW'((r_cfg_w == '0) ? 9'd1 :
               ((9'(r_cfg_w) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(r_cfg_w)));
    assign h = HW'((r_cfg_h == '0) ? 9'd1 :
               ((9'(r_cfg_h) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(r_cfg_h)));
    assign t = TW'((r_cfg_t == '0) ? 5'd1 :
               ((5'(r_cfg_t) > 5'(MAX_THICK)) ? 5'(MAX_THICK) : 5'(r_cfg_t)));
    assign t2 = T2W'(t) << 1;
    assign ow = OWW'(w) + OWW'(t2);

    assign full = r_ext || i_job_full;
    assign acc  = push && !full;

    // running max across the row window
    assign v_in = r_ext ? 8'd0 : i_in.pixel_value;
    always_comb begin
        row_max = v_in;
        for (int i = 0; i < WIN; i++) begin
            if ((T2W'(i) < t2) && (r_win[i] > row_max)) begin
                row_max = r_win[i];
            end
        end
    end

    assign col_last   = (OWW'(r_col) + 1'b1 == OWW'(w));
    assign ring_prev  = (r_ring == '0) ? RW'(R - 1) : r_ring - 1'b1;
    assign d_rows     = t2 - r_dy;
    assign drain_last = (r_dy == t2 - 1'b1) && (OWW'(r_dx) + 1'b1 == ow);

    // rows under the brush: base rows clip at the top, drain rows at the glyph bottom
    assign cnt_base  = (10'(r_row) < 10'(t2)) ? CW'(10'(r_row) + 10'd1)
                                              : CW'(10'(t2) + 10'd1);
    assign cnt_drain = (10'(h) < 10'(d_rows)) ? CW'(h) : CW'(d_rows);

    // next state and job issue
    always_comb begin
        n_cfg_w = r_cfg_w;
        n_cfg_h = r_cfg_h;
        n_cfg_t = r_cfg_t;
        n_col   = r_col;
        n_row   = r_row;
        n_ring  = r_ring;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_e     = r_e;
        n_ext   = r_ext;
        n_win   = r_win;
        restart = 1'b0;
        o_job_push = 1'b0;
        o_job      = '0;

        if (r_ext) begin
            // extra right-hand pixels of the row
            if (!i_job_full) begin
                o_job_push  = 1'b1;
                o_job.wr    = 1'b1;
                o_job.value = row_max;
                o_job.x     = gdil_pkg::JOB_X_W'(r_col);
                o_job.ring  = gdil_pkg::JOB_RING_W'(r_ring);
                o_job.cnt   = gdil_pkg::JOB_CNT_W'(cnt_base);
                n_win[0] = v_in;
                for (int i = 1; i < WIN; i++) begin
                    n_win[i] = r_win[i-1];
                end
                n_col = r_col + 1'b1;
                n_e   = r_e + 1'b1;
                if (r_e == t2 - 1'b1) begin
                    n_ext  = 1'b0;
                    n_col  = '0;
                    n_row  = r_row + 1'b1;
                    n_ring = (r_ring == RW'(R - 1)) ? '0 : r_ring + 1'b1;
                    n_dx   = '0;
                    n_dy   = '0;
                end
            end
        end else if (acc) begin
            if (i_in.operation == gdil_pkg::OP_PIXEL) begin
                if (r_row < h) begin
                    o_job_push  = 1'b1;
                    o_job.wr    = 1'b1;
                    o_job.value = row_max;
                    o_job.x     = gdil_pkg::JOB_X_W'(r_col);
                    o_job.ring  = gdil_pkg::JOB_RING_W'(r_ring);
                    o_job.cnt   = gdil_pkg::JOB_CNT_W'(cnt_base);
                    n_win[0] = v_in;
                    for (int i = 1; i < WIN; i++) begin
                        n_win[i] = r_win[i-1];
                    end
                    n_col = r_col + 1'b1;
                    if (col_last) begin
                        n_ext = 1'b1;
                        n_e   = '0;
                    end
                end
            end else if (r_row >= h) begin
                // bottom outline rows, one pixel per drain word
                o_job_push = 1'b1;
                o_job.x    = gdil_pkg::JOB_X_W'(r_dx);
                o_job.ring = gdil_pkg::JOB_RING_W'(ring_prev);
                o_job.cnt  = gdil_pkg::JOB_CNT_W'(cnt_drain);
                o_job.last = drain_last;
                if (drain_last) begin
                    restart = 1'b1;
                end else if (OWW'(r_dx) + 1'b1 == ow) begin
                    n_dx = '0;
                    n_dy = r_dy + 1'b1;
                end else begin
                    n_dx = r_dx + 1'b1;
                end
            end
        end

        // register writes restart the glyph
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gdil_pkg::CFG_WIDTH: begin
                    n_cfg_w = i_cfg_data;
                    restart = 1'b1;
                end
                gdil_pkg::CFG_HEIGHT: begin
                    n_cfg_h = i_cfg_data;
                    restart = 1'b1;
                end
                gdil_pkg::CFG_THICK: begin
                    n_cfg_t = i_cfg_data[2:0];
                    restart = 1'b1;
                end
                default: ;
            endcase
        end

        if (restart) begin
            n_col  = '0;
            n_row  = '0;
            n_ring = '0;
            n_dx   = '0;
            n_dy   = '0;
            n_e    = '0;
            n_ext  = 1'b0;
            for (int i = 0; i < WIN; i++) begin
                n_win[i] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 7'd1;
            r_cfg_h <= 7'd1;
            r_cfg_t <= 3'd1;
            r_col   <= '0;
            r_row   <= '0;
            r_ring  <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_e     <= '0;
            r_ext   <= 1'b0;
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= 8'd0;
            end
        end else begin
            r_cfg_w <= n_cfg_w;
            r_cfg_h <= n_cfg_h;
            r_cfg_t <= n_cfg_t;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ring  <= n_ring;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_e     <= n_e;
            r_ext   <= n_ext;
            r_win   <= n_win;
        end
    end
endmodule

// File: src/gdil_back.sv
// Back part: row-max store, column max over the brush and output register.
module gdil_back #(
    parameter int MAX_WIDTH = gdil_pkg::DEF_MAX_WIDTH,
    parameter int MAX_THICK = gdil_pkg::DEF_MAX_THICK
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gdil_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               empty,
    input  logic               pop,
    output gdil_pkg::t_out_word o_out
);
    localparam int R      = 2 * MAX_THICK + 1;
    localparam int STRIDE = MAX_WIDTH + 2 * MAX_THICK;
    localparam int DEPTH  = R * STRIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = $clog2(STRIDE);
    localparam int RW     = $clog2(R);
    localparam int CW     = $clog2(2 * MAX_THICK + 2);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_FIN} t_state;

    t_state         r_state;
    logic [7:0]     r_mem [DEPTH];
    logic [7:0]     r_rdata, r_max, fin_max;
    logic [XW-1:0]  r_x;
    logic [RW-1:0]  r_ring;
    logic [CW-1:0]  r_cnt, r_k;
    logic           r_last, r_rd_vld;
    logic           r_out_vld;
    gdil_pkg::t_out_word r_out;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic           mem_we, mem_re, out_free;

    assign wr_addr = AW'(RW'(i_job.ring)) * AW'(STRIDE) + AW'(XW'(i_job.x));
    assign rd_addr = AW'(r_ring) * AW'(STRIDE) + AW'(r_x);
    assign mem_we  = (r_state == S_IDLE) && !i_job_empty && i_job.wr;
    assign mem_re  = (r_state == S_RD);
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    assign out_free  = !r_out_vld || pop;
    assign fin_max   = (r_rdata > r_max) ? r_rdata : r_max;

    assign empty = !r_out_vld;
    assign o_out = r_out;

    // row-max store, one port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_job.value;
        end else if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // job sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    r_max    <= 8'd0;
                    r_k      <= '0;
                    if (!i_job_empty) begin
                        r_x     <= XW'(i_job.x);
                        r_ring  <= RW'(i_job.ring);
                        r_cnt   <= CW'(i_job.cnt);
                        r_last  <= i_job.last;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // one stored row per cycle, walking up the ring
                    r_rd_vld <= 1'b1;
                    if (r_rd_vld) begin
                        r_max <= fin_max;
                    end
                    r_ring <= (r_ring == '0) ? RW'(R - 1) : r_ring - 1'b1;
                    r_k    <= r_k + 1'b1;
                    if (r_k + 1'b1 == r_cnt) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.coverage <= fin_max;
                        r_out.last     <= r_last;
                        r_out_vld      <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/glyph_outline_dilation_unit.sv
// Top level of the glyph outline dilation unit: front, job queue, back.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+----------------------------------
//  input    | push / full               | i_in  (operation, pixel_value)
//  result   | empty / pop               | o_out (coverage, last)
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each result needs one back-end job that reads the n rows under the brush
// (up to 2*thickness+1) in turn through the single port of the row-max store.
// After a row end word the input stalls while the front issues the
// 2*thickness right-hand pixels. Reset is synchronous; the store is not
// cleared. A full job queue or an untaken result stalls each side on its own.
module glyph_outline_dilation_unit #(
    parameter int MAX_WIDTH  = gdil_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gdil_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_THICK  = gdil_pkg::DEF_MAX_THICK
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  gdil_pkg::t_in_word i_in,
    output logic               empty,
    input  logic               pop,
    output gdil_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    gdil_pkg::t_job f_job, q_job;
    logic           f_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    gdil_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_THICK  (MAX_THICK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .o_job_push  (f_push),
        .o_job       (f_job),
        .i_job_full  (q_full)
    );

    gdil_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    gdil_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_THICK (MAX_THICK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );
endmodule
